>>> rtl/core/mse_pkg.sv
// Package for the merge sort engine: payload structs, queue entry type and sizing constants.
// Used by every module under rtl/core; it depends on nothing else.
`default_nettype none

package mse_pkg;

  // Width of one stored value; the payload fields take their width from it.
  localparam int unsigned VALUE_BITS = 32;

  // Default capacity of one data set.
  localparam int unsigned DEF_MAX_ELEMS = 64;

  // Entries in the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input item.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         final_in;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         final_out;
  } out_t;

  // Classified item as it travels from the front to the back part.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } q_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/mse_front.sv
// Front part of the merge sort engine: accepts items and marks the one that closes a data set.
// Depends on mse_pkg for the payload and queue entry types.
`default_nettype none

module mse_front #(
  parameter int unsigned MAX_ELEMS = mse_pkg::DEF_MAX_ELEMS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire mse_pkg::in_t     in_data_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output mse_pkg::q_entry_t     entry_o
);

  localparam int unsigned IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

  logic [IDX_W-1:0] fcnt_q, fcnt_d;
  logic             last;

  // The item that fills the store closes the set even without its flag.
  assign last       = in_data_i.final_in || (fcnt_q == IDX_W'(MAX_ELEMS - 1));
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.value = in_data_i.sample_value;
    entry_o.last  = last;
  end

  // Position of the next item within its data set.
  always_comb begin
    fcnt_d = fcnt_q;
    if (push_o) begin
      fcnt_d = last ? '0 : fcnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mse_queue.sv
// Short queue between the front and back parts of the merge sort engine.
// Depends on mse_pkg for the entry type and depth.
`default_nettype none

module mse_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mse_pkg::q_entry_t entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output mse_pkg::q_entry_t      entry_o
);

  localparam int unsigned DEPTH = mse_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mse_pkg::q_entry_t slots_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill-count update with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mse_back.sv
// Back part of the merge sort engine: loads a data set, sorts it with bottom-up merge
// passes between two stores and emits the result. Depends on mse_pkg.
`default_nettype none

module mse_back #(
  parameter int unsigned MAX_ELEMS = mse_pkg::DEF_MAX_ELEMS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire mse_pkg::q_entry_t q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mse_pkg::out_t          out_data_o
);

  localparam int unsigned VB    = mse_pkg::VALUE_BITS;
  localparam int unsigned IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int unsigned WID_W = CNT_W + 1;
  localparam int unsigned SUM_W = CNT_W + 2;

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_RUN_SETUP = 3'd1;
  localparam logic [2:0] S_MERGE     = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_PUT  = 3'd4;

  // Ping-pong stores; store_a also takes the loaded set.
  logic [VB-1:0] store_a [MAX_ELEMS];
  logic [VB-1:0] store_b [MAX_ELEMS];

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] wptr_q, wptr_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [WID_W-1:0] width_q, width_d, width_dbl;
  logic             src_q, src_d;
  logic [CNT_W-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CNT_W-1:0] l_q, l_d, r_q, r_d, o_q, o_d, k_q, k_d;
  logic             out_valid_q, out_valid_d;
  mse_pkg::out_t    out_q, out_d;

  logic signed [VB-1:0] rd_l_q, rd_r_q;
  logic [IDX_W-1:0]     rd_addr_l, rd_addr_r, wr_addr;
  logic [VB-1:0]        wr_data;
  logic                 wr_a, wr_b;

  logic [SUM_W-1:0] mid_sum, hi_sum, n_w;
  logic [CNT_W-1:0] mid_c, hi_c;
  logic             l_live, r_live, take_left, run_done, out_load, emit_last;

  assign q_pop_o     = (state_q == S_LOAD) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign emit_last   = (k_q == n_q - CNT_W'(1));

  // Bounds of the next pair of runs, clipped to the set size.
  always_comb begin
    n_w     = SUM_W'(n_q);
    mid_sum = SUM_W'(lo_q) + SUM_W'(width_q);
    hi_sum  = mid_sum + SUM_W'(width_q);
    mid_c   = (mid_sum > n_w) ? n_q : CNT_W'(mid_sum);
    hi_c    = (hi_sum > n_w) ? n_q : CNT_W'(hi_sum);
  end

  // Head selection: while both runs have heads, the left head wins only when strictly smaller.
  assign l_live    = (l_q < mid_q);
  assign r_live    = (r_q < hi_q);
  assign take_left = l_live && (!r_live || (rd_l_q < rd_r_q));
  assign run_done  = (WID_W'(o_q) + WID_W'(1) == WID_W'(hi_q));
  assign width_dbl = width_q << 1;

  // Sequencer for load, merge passes and emission.
  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    n_d         = n_q;
    width_d     = width_q;
    src_d       = src_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    l_d         = l_q;
    r_d         = r_q;
    o_d         = o_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    wr_addr     = o_q[IDX_W-1:0];
    wr_data     = take_left ? rd_l_q : rd_r_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        wr_addr = wptr_q;
        wr_data = q_entry_i.value;
        if (q_valid_i) begin
          wr_a = 1'b1;
          n_d  = CNT_W'(wptr_q) + CNT_W'(1);
          if (q_entry_i.last) begin
            wptr_d  = '0;
            width_d = WID_W'(1);
            src_d   = 1'b0;
            lo_d    = '0;
            k_d     = '0;
            state_d = (n_d > CNT_W'(1)) ? S_RUN_SETUP : S_EMIT_RD;
          end else begin
            wptr_d = wptr_q + IDX_W'(1);
          end
        end
      end
      S_RUN_SETUP: begin
        mid_d   = mid_c;
        hi_d    = hi_c;
        l_d     = lo_q;
        r_d     = mid_c;
        o_d     = lo_q;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        wr_a = src_q;
        wr_b = !src_q;
        l_d  = l_q + CNT_W'(take_left);
        r_d  = r_q + CNT_W'(!take_left);
        o_d  = o_q + CNT_W'(1);
        if (run_done) begin
          if (hi_q == n_q) begin
            // Pass complete: double the run width and swap stores.
            width_d = width_dbl;
            src_d   = !src_q;
            lo_d    = '0;
            k_d     = '0;
            state_d = (width_dbl >= WID_W'(n_q)) ? S_EMIT_RD : S_RUN_SETUP;
          end else begin
            lo_d    = hi_q;
            state_d = S_RUN_SETUP;
          end
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (out_load) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = rd_l_q;
          out_d.final_out    = emit_last;
          k_d                = k_q + CNT_W'(1);
          state_d            = emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Read addresses follow the emit index while emitting and the next heads otherwise.
  always_comb begin
    if (state_q == S_EMIT_RD || state_q == S_EMIT_PUT) begin
      rd_addr_l = k_q[IDX_W-1:0];
      rd_addr_r = k_q[IDX_W-1:0];
    end else begin
      rd_addr_l = l_d[IDX_W-1:0];
      rd_addr_r = r_d[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      wptr_q      <= '0;
      n_q         <= '0;
      width_q     <= WID_W'(1);
      src_q       <= 1'b0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      l_q         <= '0;
      r_q         <= '0;
      o_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      n_q         <= n_d;
      width_q     <= width_d;
      src_q       <= src_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      l_q         <= l_d;
      r_q         <= r_d;
      o_q         <= o_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Store writes and registered reads from the current source store.
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      store_a[wr_addr] <= wr_data;
    end
    if (wr_b) begin
      store_b[wr_addr] <= wr_data;
    end
    rd_l_q <= src_q ? store_b[rd_addr_l] : store_a[rd_addr_l];
    rd_r_q <= src_q ? store_b[rd_addr_r] : store_a[rd_addr_r];
  end

`ifndef SYNTHESIS
  a_heads_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (l_q <= mid_q) && (r_q <= hi_q) && (o_q < hi_q))
    else $error("merge heads left their runs");

  a_merge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |->
      (WID_W'(o_q) + WID_W'(mid_q) == WID_W'(l_q) + WID_W'(r_q)))
    else $error("merge output index out of step with the heads");

  a_final_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_PUT && out_load && emit_last) |=> (state_q == S_LOAD))
    else $error("sequencer did not return to loading after the final item");

  a_partial_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_entry_i.last) |=> (state_q == S_LOAD))
    else $error("sort started before the set was closed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/merge_sort_engine.sv
// Merge sort engine: loads a data set, sorts it bottom-up and emits it in order.
// Items load one per cycle while the queue holds them; no new item is loaded while a set
// is sorted or emitted. Each merge pass sets up and then merges every run pair in turn,
// and each value is emitted by a read step and a put step that waits on an output stall.
// Reset clears the control state; the stores hold no meaningful data until loaded.
// Depends on mse_pkg, mse_front, mse_queue and mse_back.
`default_nettype none

module merge_sort_engine #(
  parameter int unsigned MAX_ELEMS = mse_pkg::DEF_MAX_ELEMS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire mse_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mse_pkg::out_t      out_data_o
);

  logic              push, full, pop, q_valid;
  mse_pkg::q_entry_t push_entry, pop_entry;

  // Front part: accept and classify items.
  mse_front #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue that decouples the two parts.
  mse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  // Back part: store, sort and emit.
  mse_back #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for merge_sort_engine: sends data sets of signed Q16.16 values
// and checks every sorted item against a bottom-up merge sort kept inside the testbench.
// Depends on mse_pkg and the merge_sort_engine RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP     = mse_pkg::DEF_MAX_ELEMS;
  localparam int unsigned STUCK_LIMIT = 6000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 90;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  mse_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  mse_pkg::out_t out_data_o;

  // Stores of the sorting predictor: values of the open set, then the merge target.
  logic signed [mse_pkg::VALUE_BITS-1:0] run_src [SET_CAP];
  logic signed [mse_pkg::VALUE_BITS-1:0] run_dst [SET_CAP];
  int unsigned   set_count = 0;
  mse_pkg::out_t sorted_queue [$];

  // Run control and bookkeeping.
  bit          send_gaps   = 1'b1;
  bit          recv_gaps   = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned results_got = 0;
  int unsigned sets_closed = 0;
  int unsigned stuck_cycles = 0;

  merge_sort_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Sort the first n values of run_src in place, merging runs of width 1, 2, 4, ...
  // On a tie the right element is taken first.
  task automatic merge_sort_set(input int unsigned n);
    int unsigned width, lo, mid, hi, l, r, o;
    for (width = 1; width < n; width = width * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * width) begin
        mid = (lo + width > n) ? n : lo + width;
        hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
        l = lo;
        r = mid;
        o = lo;
        while (l < mid && r < hi) begin
          if (run_src[l] < run_src[r]) begin
            run_dst[o] = run_src[l];
            l = l + 1;
          end else begin
            run_dst[o] = run_src[r];
            r = r + 1;
          end
          o = o + 1;
        end
        while (l < mid) begin
          run_dst[o] = run_src[l];
          l = l + 1;
          o = o + 1;
        end
        while (r < hi) begin
          run_dst[o] = run_src[r];
          r = r + 1;
          o = o + 1;
        end
      end
      run_src = run_dst;
    end
  endtask

  // Load one accepted item; a last item or a full store closes the set and queues its
  // sorted values.
  task automatic load_sample(input mse_pkg::in_t item);
    int unsigned k;
    mse_pkg::out_t res;
    run_src[set_count] = item.sample_value;
    set_count = set_count + 1;
    if (item.final_in || set_count >= SET_CAP) begin
      merge_sort_set(set_count);
      for (k = 0; k < set_count; k++) begin
        res.sorted_value = run_src[k];
        res.final_out    = (k + 1 == set_count);
        sorted_queue.push_back(res);
      end
      set_count   = 0;
      sets_closed = sets_closed + 1;
    end
  endtask

  // Offer one item, with idle cycles first at random, and wait until the block takes it.
  task automatic send_item(input logic signed [mse_pkg::VALUE_BITS-1:0] value,
                           input bit last);
    mse_pkg::in_t item;
    item.sample_value = value;
    item.final_in     = last;
    while (send_gaps && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    load_sample(item);
    items_sent = items_sent + 1;
  endtask

  // Random value: full range, a narrow range that repeats often, or an extreme.
  function automatic logic signed [mse_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(3))
      0: pick_value = $urandom_range(8) - 4;
      1: pick_value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: pick_value = $urandom;
    endcase
  endfunction

  // Send one set of n random values; the flag on the closing item is chosen by the caller.
  task automatic send_random_set(input int unsigned n, input bit last_flag);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      send_item(pick_value(), (k + 1 == n) ? last_flag : 1'b0);
    end
  endtask

  task automatic test_single_element();
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'shFFFF_FFFF, 1'b0);
    send_item(32'sh0000_0001, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0001_0000, 1'b1);
  endtask

  // Equal heads must resolve toward the right run.
  task automatic test_equal_values();
    send_item(32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0005, 1'b0);
    send_item(-32'sh0000_0005, 1'b0);
    send_item(32'sh0000_0005, 1'b1);
  endtask

  task automatic test_two_elements();
    send_item(32'sh0000_0003, 1'b0);
    send_item(-32'sh0000_0003, 1'b1);
    send_item(-32'sh0000_0003, 1'b0);
    send_item(32'sh0000_0003, 1'b1);
  endtask

  // A full store closes the set without the flag; the next item opens a new set.
  task automatic test_full_store();
    send_random_set(SET_CAP, 1'b0);
    send_random_set(2, 1'b1);
  endtask

  // The receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    send_random_set(8, 1'b1);
    send_random_set(8, 1'b1);
    send_random_set(6, 1'b1);
    send_gaps = 1'b1;
  endtask

  // A stretch with neither side idling.
  task automatic test_back_to_back();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_random_set(5, 1'b1);
    send_random_set(12, 1'b1);
    send_random_set(3, 1'b1);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // Random sets, mostly small, now and then a full one with either closing flag.
  task automatic test_random_sets();
    int unsigned done;
    int unsigned n;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(14) == 0) begin
        n = SET_CAP;
      end else if ($urandom_range(3) == 0) begin
        n = $urandom_range(13, 24);
      end else begin
        n = $urandom_range(1, 12);
      end
      send_random_set(n, (n == SET_CAP) ? 1'($urandom_range(1)) : 1'b1);
      done = done + n;
    end
  endtask

  // Check each accepted result and drive the receiver's stall for the next cycle.
  initial begin
    mse_pkg::out_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_got = results_got + 1;
        if (sorted_queue.size() == 0) begin
          $display("%0t: unexpected item: value %0d final %0b", $time,
                   out_data_o.sorted_value, out_data_o.final_out);
          mismatches = mismatches + 1;
        end else begin
          want = sorted_queue.pop_front();
          if (out_data_o.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time,
                     want.sorted_value, out_data_o.sorted_value);
            mismatches = mismatches + 1;
          end
          if (out_data_o.final_out !== want.final_out) begin
            $display("%0t: final_out expected %0b actual %0b", $time,
                     want.final_out, out_data_o.final_out);
            mismatches = mismatches + 1;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= recv_gaps && ($urandom_range(99) < 35);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
               stuck_cycles, sorted_queue.size());
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_element();
    test_extremes();
    test_equal_values();
    test_two_elements();
    test_full_store();
    test_backpressure();
    test_back_to_back();
    test_random_sets();

    in_valid_i <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d items in %0d data sets and checked %0d sorted items.",
             items_sent, sets_closed, results_got);
    $display("Sets ranged from one value to a full store, with stalls and a long hold-off.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> merge_sort_engine.f
rtl/core/mse_pkg.sv
rtl/core/mse_front.sv
rtl/core/mse_queue.sv
rtl/core/mse_back.sv
rtl/core/merge_sort_engine.sv
sim/testbench.sv
